// ===== rtl/iee_pkg.sv =====
package iee_pkg;

    // Width of the arithmetic datapath; all sums and products wrap at this width.
    localparam int VALUE_W = 32;

    // Parser states.
    localparam logic [2:0] ST_START  = 3'd0;
    localparam logic [2:0] ST_ZERO   = 3'd1;
    localparam logic [2:0] ST_NUM    = 3'd2;
    localparam logic [2:0] ST_OP     = 3'd3;
    localparam logic [2:0] ST_ACCEPT = 3'd4;
    localparam logic [2:0] ST_REJECT = 3'd5;

    // Character classes.
    localparam logic [1:0] CLS_ZERO  = 2'd0;
    localparam logic [1:0] CLS_DIGIT = 2'd1;
    localparam logic [1:0] CLS_OP    = 2'd2;
    localparam logic [1:0] CLS_OTHER = 2'd3;

    // Commands passed from the front end to the back end.
    localparam logic [2:0] ACT_NONE  = 3'd0;
    localparam logic [2:0] ACT_DIGIT = 3'd1;
    localparam logic [2:0] ACT_MUL   = 3'd2;
    localparam logic [2:0] ACT_ADD   = 3'd3;
    localparam logic [2:0] ACT_SUB   = 3'd4;

    // ASCII codes.
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_1     = 8'h31;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;

    typedef struct packed {
        logic [7:0] char_code;
        logic       is_last;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] value;
        logic               valid_res;
    } t_out_item;

    typedef struct packed {
        logic [2:0] act;
        logic [3:0] digit;
        logic       is_last;
        logic       ok;
    } t_cmd;

    // Sorts one character into its class.
    function automatic logic [1:0] char_class(input logic [7:0] c);
        logic [1:0] cls;
        cls = CLS_OTHER;
        if (c == CH_0) begin
            cls = CLS_ZERO;
        end else if (c inside {[CH_1:CH_9]}) begin
            cls = CLS_DIGIT;
        end else if (c inside {CH_PLUS, CH_MINUS, CH_STAR}) begin
            cls = CLS_OP;
        end
        return cls;
    endfunction

    // Transition table of the syntax checker.
    function automatic logic [2:0] next_state(input logic [2:0] st, input logic [1:0] cls);
        logic [2:0] nst;
        nst = ST_REJECT;
        case (st)
            ST_START, ST_OP: begin
                case (cls)
                    CLS_ZERO:  nst = ST_ZERO;
                    CLS_DIGIT: nst = ST_NUM;
                    default:   nst = ST_REJECT;
                endcase
            end
            ST_ZERO: begin
                nst = (cls == CLS_OP) ? ST_OP : ST_REJECT;
            end
            ST_NUM: begin
                case (cls)
                    CLS_ZERO, CLS_DIGIT: nst = ST_NUM;
                    CLS_OP:              nst = ST_OP;
                    default:             nst = ST_REJECT;
                endcase
            end
            default: nst = ST_REJECT;
        endcase
        return nst;
    endfunction

endpackage

// ===== rtl/infix_expression_evaluator_top.sv =====
// Streaming evaluator for infix expressions over +, - and * on decimal numbers.
// Input channel: one ASCII character per transaction (i_data.char_code), with
// i_data.is_last set on the final character of an expression. A transaction
// is taken at a rising edge where i_valid is high and o_stall is low.
// Output channel: one result per expression, o_data.value (32-bit two's
// complement, wrapping) and o_data.valid_res, which is 0 for a syntax error;
// the value is then 0. Taken where o_valid is high and i_stall is low.
// Throughput is one character per cycle while the command queue has room, set by
// the combinational parser step and the one multiplier used per operator in the back end.
// After the final character is taken, the result is formed in steps: queue read,
// product of the last term, final add.
// A stall on an offered result holds the result register and freezes the back end;
// the front end keeps taking characters until the command queue
// (QUEUE_DEPTH entries) is full, then raises o_stall.
// Reset (synchronous, active low) returns the parser to its start state,
// empties the queue, sets the accumulators to their start values and drops o_valid.
module infix_expression_evaluator_top
    import iee_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_in_item  i_data,
    output logic      o_stall,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_data
);

    logic w_full;
    logic w_empty;
    logic w_push;
    logic w_pop;
    t_cmd w_cmd_in;
    t_cmd w_cmd_out;

    // Parser and command encoder.
    iee_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_stall (o_stall),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_cmd   (w_cmd_in)
    );

    // Command queue between parser and arithmetic.
    iee_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd_in),
        .i_pop   (w_pop),
        .o_cmd   (w_cmd_out),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    // Arithmetic back end and result register.
    iee_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd_out),
        .i_empty (w_empty),
        .o_pop   (w_pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

endmodule

// ===== rtl/iee_front.sv =====
module iee_front
    import iee_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_in_item i_data,
    output logic     o_stall,
    input  logic     i_full,
    output logic     o_push,
    output t_cmd     o_cmd
);

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic [2:0] w_cur;
    logic [2:0] w_nst;
    logic [1:0] w_cls;

    // A character is taken whenever the queue has room.
    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

    // Classify the character and step the syntax checker.
    assign w_cls = char_class(i_data.char_code);
    assign w_cur = (r_state > ST_REJECT) ? ST_REJECT : r_state;
    assign w_nst = next_state(w_cur, w_cls);

    // Translate the transition into a command for the back end.
    always_comb begin
        o_cmd.act = ACT_NONE;
        if (w_nst == ST_ZERO || w_nst == ST_NUM) begin
            o_cmd.act = ACT_DIGIT;
        end else if (w_nst == ST_OP) begin
            if (i_data.char_code == CH_STAR) begin
                o_cmd.act = ACT_MUL;
            end else if (i_data.char_code == CH_MINUS) begin
                o_cmd.act = ACT_SUB;
            end else begin
                o_cmd.act = ACT_ADD;
            end
        end
        o_cmd.digit   = i_data.char_code[3:0];
        o_cmd.is_last = i_data.is_last;
        o_cmd.ok      = (w_nst == ST_ZERO) || (w_nst == ST_NUM);
    end

    // The parser returns to its start state after the final character.
    always_comb begin
        n_state = r_state;
        if (o_push) begin
            n_state = i_data.is_last ? ST_START : w_nst;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_START;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/iee_queue.sv =====
module iee_queue
    import iee_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_full,
    output logic o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic [PTR_W-1:0] n_wr;
    logic [PTR_W-1:0] n_rd;
    logic [CNT_W-1:0] n_cnt;
    logic             w_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rd];
    assign w_pop   = i_pop && !o_empty;

    // Pointer and fill count update.
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == LAST_PTR) ? '0 : r_wr + 1'b1;
        end
        if (w_pop) begin
            n_rd = (r_rd == LAST_PTR) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !w_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

// ===== rtl/iee_back.sv =====
module iee_back
    import iee_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_cmd,
    input  logic      i_empty,
    output logic      o_pop,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_data
);

    localparam logic [VALUE_W-1:0] ONE_V   = VALUE_W'(1);
    localparam logic [VALUE_W-1:0] MINUS_V = '1;

    // Accumulators and the pending product of the last operator.
    logic [VALUE_W-1:0] r_num,   n_num;
    logic [VALUE_W-1:0] r_term,  n_term;
    logic [VALUE_W-1:0] r_total, n_total;
    logic               r_pend,  n_pend;
    logic               r_pend_mul, n_pend_mul;
    logic [VALUE_W-1:0] r_prod,  n_prod;

    // Final-result pipeline.
    logic               r_f1_v, r_f2_v, r_ov;
    logic               r_f1_ok, r_f2_ok;
    logic [VALUE_W-1:0] r_f1_term, r_f1_total, r_f1_num;
    logic [VALUE_W-1:0] r_f2_prod, r_f2_total;
    t_out_item          r_out;

    logic                 w_en;
    logic                 w_take;
    logic [VALUE_W-1:0]   w_term_cur;
    logic [VALUE_W-1:0]   w_total_cur;
    logic [VALUE_W-1:0]   w_num_dig;
    logic [2*VALUE_W-1:0] w_mult;
    logic [2*VALUE_W-1:0] w_fmult;
    logic [VALUE_W-1:0]   w_res;

    // The whole back end advances whenever the output register can move.
    assign w_en   = !r_ov || !i_stall;
    assign w_take = w_en && !i_empty;
    assign o_pop  = w_take;

    // Fold in the product left pending by the previous operator.
    assign w_term_cur  = (r_pend && r_pend_mul) ? r_prod : r_term;
    assign w_total_cur = (r_pend && !r_pend_mul) ? r_total + r_prod : r_total;

    // Decimal accumulate: number * 10 + digit.
    assign w_num_dig = (r_num << 3) + (r_num << 1) + VALUE_W'(i_cmd.digit);

    assign w_mult  = w_term_cur * r_num;
    assign w_fmult = r_f1_term * r_f1_num;
    assign w_res   = r_f2_total + r_f2_prod;

    // Accumulator update for one command.
    always_comb begin
        n_num      = r_num;
        n_term     = r_term;
        n_total    = r_total;
        n_pend     = r_pend;
        n_pend_mul = r_pend_mul;
        n_prod     = r_prod;
        if (w_en) begin
            n_term  = w_term_cur;
            n_total = w_total_cur;
            n_pend  = 1'b0;
        end
        if (w_take) begin
            case (i_cmd.act)
                ACT_DIGIT: begin
                    n_num = w_num_dig;
                end
                ACT_MUL: begin
                    n_prod     = w_mult[VALUE_W-1:0];
                    n_pend     = 1'b1;
                    n_pend_mul = 1'b1;
                    n_num      = '0;
                end
                ACT_ADD, ACT_SUB: begin
                    n_prod     = w_mult[VALUE_W-1:0];
                    n_pend     = 1'b1;
                    n_pend_mul = 1'b0;
                    n_term     = (i_cmd.act == ACT_SUB) ? MINUS_V : ONE_V;
                    n_num      = '0;
                end
                default: begin
                end
            endcase
            // The end of an expression restores the start values.
            if (i_cmd.is_last) begin
                n_num   = '0;
                n_term  = ONE_V;
                n_total = '0;
                n_pend  = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num      <= '0;
            r_term     <= ONE_V;
            r_total    <= '0;
            r_pend     <= 1'b0;
            r_pend_mul <= 1'b0;
            r_f1_v     <= 1'b0;
            r_f2_v     <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            r_num      <= n_num;
            r_term     <= n_term;
            r_total    <= n_total;
            r_pend     <= n_pend;
            r_pend_mul <= n_pend_mul;
            if (w_en) begin
                r_f1_v <= w_take && i_cmd.is_last;
                r_f2_v <= r_f1_v;
                r_ov   <= r_f2_v;
            end
        end
    end

    // Result datapath: snapshot, multiply, then add and clamp invalid to zero.
    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        if (w_en) begin
            r_f1_ok    <= i_cmd.ok;
            r_f1_term  <= w_term_cur;
            r_f1_total <= w_total_cur;
            r_f1_num   <= (i_cmd.act == ACT_DIGIT) ? w_num_dig : r_num;
            r_f2_ok    <= r_f1_ok;
            r_f2_prod  <= w_fmult[VALUE_W-1:0];
            r_f2_total <= r_f1_total;
            r_out.valid_res <= r_f2_ok;
            r_out.value     <= r_f2_ok ? signed'(32'(w_res)) : '0;
        end
    end

    assign o_valid = r_ov;
    assign o_data  = r_out;

endmodule

// ===== rtl/iee_checker.sv =====
module iee_checker
    import iee_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_valid,
    input logic      o_stall,
    input logic      o_valid,
    input logic      i_stall,
    input t_out_item o_data
);

    // A stalled result stays offered.
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    // A stalled result does not change.
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_data))
        else $error("result changed while stalled");

    // A rejected expression reports a zero value.
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.valid_res |-> o_data.value == 32'sd0)
        else $error("rejected expression with nonzero value");

    // The queue only fills on an accepted character.
    a_stall_on_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_valid && !o_stall) |=> !$rose(o_stall))
        else $error("input stall raised without an accepted character");

endmodule

bind infix_expression_evaluator_top iee_checker u_iee_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);

// ===== tb/sv/infix_expression_evaluator_top_tb.sv =====
module infix_expression_evaluator_top_tb
    import iee_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Cycles without any transaction on either channel before the run is abandoned.
    localparam int STALL_LIMIT = 3000;
    // Length of the long output hold used to back the block up.
    localparam int LONG_HOLD   = 300;
    // Cycles allowed after the last result for anything unexpected to show up.
    localparam int TAIL_CYCLES = 10;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    t_in_item  i_data  = '0;
    logic      o_stall;
    logic      o_valid;
    logic      i_stall = 1'b0;
    t_out_item o_data;

    // Expected results in arrival order.
    t_out_item exp_results[$];
    // Characters of the expression about to be sent.
    logic [7:0] expr_chars[$];

    // Shadow of the evaluator state.
    logic [2:0]  parse_st   = ST_START;
    logic [31:0] cur_number = '0;
    logic [31:0] cur_term   = 32'd1;
    logic [31:0] run_total  = '0;

    // Traffic controls shared between the test tasks and the receiver.
    logic tx_idle_en    = 1'b0;
    logic rx_idle_en    = 1'b0;
    logic long_hold_req = 1'b0;
    int   stall_left    = 0;
    int   idle_cycles   = 0;

    int mismatches      = 0;
    int chars_sent      = 0;
    int exprs_sent      = 0;
    int results_checked = 0;
    int rejects_seen    = 0;

    always #5 i_clk = ~i_clk;

    infix_expression_evaluator_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    // Advances the shadow evaluator by one character; returns 1 when a result is due.
    function automatic logic evaluate_char(input t_in_item item, output t_out_item res);
        logic [2:0]  nxt;
        logic        is_zero;
        logic        is_digit;
        logic        is_op;
        logic [31:0] prod;
        logic        ok;
        res      = '0;
        is_zero  = (item.char_code == CH_0);
        is_digit = (item.char_code >= CH_1) && (item.char_code <= CH_9);
        is_op    = (item.char_code == CH_PLUS) || (item.char_code == CH_MINUS) ||
                   (item.char_code == CH_STAR);

        // Syntax automaton.
        case (parse_st)
            ST_START, ST_OP: begin
                nxt = is_zero ? ST_ZERO : (is_digit ? ST_NUM : ST_REJECT);
            end
            ST_ZERO: begin
                nxt = is_op ? ST_OP : ST_REJECT;
            end
            ST_NUM: begin
                nxt = (is_zero || is_digit) ? ST_NUM : (is_op ? ST_OP : ST_REJECT);
            end
            default: begin
                nxt = ST_REJECT;
            end
        endcase
        parse_st = nxt;

        // Accumulate digits, or close a factor or a term on an operator.
        if (nxt == ST_ZERO || nxt == ST_NUM) begin
            cur_number = cur_number * 32'd10 + 32'(item.char_code - CH_0);
        end else if (nxt == ST_OP) begin
            prod = cur_term * cur_number;
            if (item.char_code == CH_STAR) begin
                cur_term = prod;
            end else begin
                run_total = run_total + prod;
                cur_term  = (item.char_code == CH_MINUS) ? '1 : 32'd1;
            end
            cur_number = '0;
        end

        if (!item.is_last) begin
            return 1'b0;
        end

        // Final character: produce the result and start over.
        ok = (nxt == ST_ZERO || nxt == ST_NUM);
        res.valid_res = ok;
        res.value     = ok ? run_total + cur_term * cur_number : '0;
        parse_st   = ST_START;
        cur_number = '0;
        cur_term   = 32'd1;
        run_total  = '0;
        return 1'b1;
    endfunction

    function automatic logic [7:0] pick_operator();
        logic [7:0] op;
        case ($urandom_range(0, 2))
            0:       op = CH_PLUS;
            1:       op = CH_MINUS;
            default: op = CH_STAR;
        endcase
        return op;
    endfunction

    // Offers one character and returns once the transaction is accepted; valid stays high.
    task automatic send_char(input logic [7:0] code, input logic last);
        int        gap;
        t_in_item  item;
        t_out_item res;
        item.char_code = code;
        item.is_last   = last;
        if (tx_idle_en && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 10);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= item;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        chars_sent++;
        if (last) begin
            exprs_sent++;
        end
        if (evaluate_char(item, res)) begin
            exp_results.push_back(res);
        end
    endtask

    task automatic send_text(input string text);
        for (int k = 0; k < text.len(); k++) begin
            send_char(text[k], k == text.len() - 1);
        end
    endtask

    task automatic send_expression();
        for (int k = 0; k < expr_chars.size(); k++) begin
            send_char(expr_chars[k], k == expr_chars.size() - 1);
        end
    endtask

    // Builds a random expression: mostly well formed, some broken, some pure noise.
    task automatic make_expression();
        int n_terms;
        int n_digits;
        int pos;
        expr_chars.delete();
        n_terms = $urandom_range(1, 4);
        for (int t = 0; t < n_terms; t++) begin
            if (t > 0) begin
                expr_chars.push_back(pick_operator());
            end
            if ($urandom_range(0, 7) == 0) begin
                expr_chars.push_back(CH_0);
            end else begin
                // Long numbers now and then, so that the wrap-around is exercised.
                n_digits = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 10)
                                                       : $urandom_range(1, 3);
                expr_chars.push_back(CH_0 + 8'($urandom_range(1, 9)));
                for (int d = 1; d < n_digits; d++) begin
                    expr_chars.push_back(CH_0 + 8'($urandom_range(0, 9)));
                end
            end
        end

        case ($urandom_range(0, 9))
            7: begin
                // Overwrite one character with an arbitrary code.
                pos = $urandom_range(0, expr_chars.size() - 1);
                expr_chars[pos] = 8'($urandom_range(0, 255));
            end
            8: begin
                case ($urandom_range(0, 3))
                    0: expr_chars.push_back(pick_operator());
                    1: expr_chars.push_front(pick_operator());
                    2: begin
                        pos = $urandom_range(0, expr_chars.size());
                        expr_chars.insert(pos, pick_operator());
                    end
                    default: begin
                        // A digit behind a lone zero.
                        expr_chars.push_front(CH_0 + 8'($urandom_range(0, 9)));
                        expr_chars.push_front(CH_0);
                    end
                endcase
            end
            9: begin
                expr_chars.delete();
                repeat ($urandom_range(1, 4)) expr_chars.push_back(8'($urandom_range(0, 255)));
            end
            default: begin
            end
        endcase
    endtask

    // Lowers valid and waits until every expected result has been taken.
    task automatic wait_for_results();
        i_valid <= 1'b0;
        while (exp_results.size() != 0) @(posedge i_clk);
    endtask

    // Short expressions covering the syntax rules and each operator.
    task automatic test_directed();
        send_text("9");
        send_text("0");
        send_text("05");
        send_text("-1");
        send_text("2*+3");
        send_text("4-");
        send_text("1a");
        send_char(8'h00, 1'b1);
        send_text("1+3*4-9");
        send_char(CH_1, 1'b0);
        send_char(8'hFF, 1'b1);
        wait_for_results();
    endtask

    // Random expressions with idling on both channels.
    task automatic test_random_traffic(input int n_chars);
        int start;
        start      = chars_sent;
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        while (chars_sent - start < n_chars) begin
            make_expression();
            send_expression();
        end
    endtask

    // The receiver holds off for a long stretch while characters keep coming.
    task automatic test_output_hold();
        int start;
        start         = chars_sent;
        tx_idle_en    = 1'b0;
        long_hold_req = 1'b1;
        while (chars_sent - start < 60) begin
            make_expression();
            send_expression();
        end
        tx_idle_en = 1'b1;
    endtask

    // Every few expressions the sender stops until the block has drained.
    task automatic test_drain_pauses();
        for (int e = 0; e < 30; e++) begin
            make_expression();
            send_expression();
            if (e % 3 == 2) begin
                wait_for_results();
            end
        end
    endtask

    // Back-to-back traffic with no idling on either side.
    task automatic test_full_rate(input int n_chars);
        int start;
        start      = chars_sent;
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        while (chars_sent - start < n_chars) begin
            make_expression();
            send_expression();
        end
    endtask

    task automatic finish_run();
        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Sent %0d characters in %0d expressions with idling, a long output hold,",
                 chars_sent, exprs_sent);
        $display("drain pauses and full-rate traffic; %0d results checked, %0d rejected.",
                 results_checked, rejects_seen);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    endtask

    // Checks each result transaction and decides the output stall for the next cycle.
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (exp_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got value %0d valid %0b",
                             $realtime, o_data.value, o_data.valid_res);
                    mismatches++;
                end else begin
                    want = exp_results.pop_front();
                    results_checked++;
                    if (!want.valid_res) begin
                        rejects_seen++;
                    end
                    if (o_data.valid_res !== want.valid_res) begin
                        $display("%0t: valid_res mismatch, expected %0b, got %0b",
                                 $realtime, want.valid_res, o_data.valid_res);
                        mismatches++;
                    end
                    if (o_data.value !== want.value) begin
                        $display("%0t: value mismatch, expected %0d, got %0d",
                                 $realtime, want.value, o_data.value);
                        mismatches++;
                    end
                end
            end

            if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                stall_left    = LONG_HOLD - 1;
                i_stall <= 1'b1;
            end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 9);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Watchdog on cycles in which neither channel completes a transaction.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: no transaction for %0d cycles, %0d results still expected",
                         $realtime, idle_cycles, exp_results.size());
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random_traffic(900);
        test_output_hold();
        test_drain_pauses();
        test_full_rate(270);
        finish_run();
    end

endmodule

// ===== infix_expression_evaluator_top.f =====
rtl/iee_pkg.sv
rtl/iee_front.sv
rtl/iee_queue.sv
rtl/iee_back.sv
rtl/infix_expression_evaluator_top.sv
rtl/iee_checker.sv
tb/sv/infix_expression_evaluator_top_tb.sv
